/* design/ftc_pkg.sv */
// shared types and constants of the fan tach one-shot capture block
// no dependencies
`default_nettype none

package ftc_pkg;

    localparam int STAMP_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int PERIOD_W   = STAMP_BITS + 1;
    localparam int CLK_W      = 20;
    localparam int FREQ_W     = 28;
    localparam int DIVD_W     = CLK_W + FRAC_BITS;
    localparam int RPM_W      = 33;
    localparam int COUNT_W    = 16;
    localparam int MS_W       = 32;
    localparam int CFG_MS_W   = 16;
    localparam int MUX_W      = 5;
    localparam int REQ_W      = 2;
    localparam int CFG_IDX_W  = 2;

    localparam logic [COUNT_W-1:0]  COUNT_MAX     = '1;
    localparam logic [CFG_MS_W-1:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [CFG_MS_W-1:0] SETTLE_RESET  = 16'd10;
    localparam logic [CLK_W-1:0]    CLOCK_RESET   = 20'd10000;

    // request codes on the input channel
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_EDGE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_START = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK   = 2'd2;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_EDGE,
        CMD_START,
        CMD_NONE
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [STAMP_BITS-1:0] stamp;
        logic [MUX_W-1:0]      mux;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_if;

endpackage

`default_nettype wire

/* design/fan_tach_one_shot_capture.sv */
// top level of the fan tach one-shot capture block
// depends on ftc_pkg, ftc_front and ftc_back
//
// usage:
//   input channel (i_in_valid / o_in_stall) takes one item per handshake:
//   a millisecond tick, a tach edge with its capture stamp, or a one-shot
//   start with a mux selection. every item yields exactly one result on the
//   output channel (o_out_valid / i_out_stall).
//   an accepted item passes through the command queue and the back end to
//   the result register; an edge that measures a period also runs the
//   28-bit restoring divider before its result is registered.
//   the back end takes no new item until its result is loaded, so a
//   measuring edge holds later items in the queue while it divides.
//   a two-entry command queue sits between the front and the back end, so
//   items are taken while a result waits. when the receiver stalls, the
//   result register holds, the back end stops once its next result is
//   ready, and the queue fills until o_in_stall rises.
//   reset (synchronous, active low) clears all measurement state and loads
//   the default configuration; configuration is written through
//   i_cfg_we / i_cfg_index / i_cfg_data while the block is idle.
`default_nettype none

module fan_tach_one_shot_capture (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [ftc_pkg::REQ_W-1:0]      i_req_type,
    input  wire logic [ftc_pkg::STAMP_BITS-1:0] i_capture_stamp,
    input  wire logic [ftc_pkg::MUX_W-1:0]      i_mux_request,
    input  wire logic                           i_cfg_we,
    input  wire logic [ftc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ftc_pkg::CLK_W-1:0]      i_cfg_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_active,
    output logic                                o_done_pulse,
    output logic [ftc_pkg::FREQ_W-1:0]          o_frequency_q8,
    output logic [ftc_pkg::RPM_W-1:0]           o_rpm_q8,
    output logic [ftc_pkg::COUNT_W-1:0]         o_edge_count,
    output logic [ftc_pkg::PERIOD_W-1:0]        o_period_ticks,
    output logic                                o_timed_out,
    output logic [ftc_pkg::MUX_W-1:0]           o_mux_drive
);
    import ftc_pkg::*;

    t_q_if q;
    logic  pop;

    ftc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_capture_stamp (i_capture_stamp),
        .i_mux_request   (i_mux_request),
        .o_q             (q),
        .i_pop           (pop)
    );

    ftc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q            (q),
        .o_pop          (pop),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_active       (o_active),
        .o_done_pulse   (o_done_pulse),
        .o_frequency_q8 (o_frequency_q8),
        .o_rpm_q8       (o_rpm_q8),
        .o_edge_count   (o_edge_count),
        .o_period_ticks (o_period_ticks),
        .o_timed_out    (o_timed_out),
        .o_mux_drive    (o_mux_drive)
    );

endmodule

`default_nettype wire

/* design/ftc_div.sv */
// iterative restoring divider, one quotient bit per cycle
// depends on ftc_pkg
`default_nettype none

module ftc_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [ftc_pkg::DIVD_W-1:0]  i_dividend,
    input  wire logic [ftc_pkg::PERIOD_W-1:0] i_divisor,
    output logic                             o_done,
    output logic [ftc_pkg::DIVD_W-1:0]       o_quotient
);
    import ftc_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic [CNT_W-1:0]    r_cnt;
    logic [PERIOD_W-1:0] r_div;
    logic [PERIOD_W-1:0] r_rem;
    logic [DIVD_W-1:0]   r_quo;
    logic                r_done;

    logic [PERIOD_W:0]   trial;
    logic                fits;

    assign trial = {r_rem, r_quo[DIVD_W-1]};
    assign fits  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(DIVD_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_cnt != '0) begin
            if (fits) begin
                r_rem <= PERIOD_W'(trial - {1'b0, r_div});
            end else begin
                r_rem <= trial[PERIOD_W-1:0];
            end
            r_quo <= {r_quo[DIVD_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

/* design/ftc_front.sv */
// front end: accepts items, decodes the request and queues commands
// depends on ftc_pkg
`default_nettype none

module ftc_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [ftc_pkg::REQ_W-1:0]      i_req_type,
    input  wire logic [ftc_pkg::STAMP_BITS-1:0] i_capture_stamp,
    input  wire logic [ftc_pkg::MUX_W-1:0]      i_mux_request,
    output ftc_pkg::t_q_if                      o_q,
    input  wire logic                           i_pop
);
    import ftc_pkg::*;

    localparam int DEPTH = 2;

    t_cmd        r_mem [DEPTH];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;

    t_cmd        cmd;
    logic        push;
    logic        pop;

    always_comb begin
        cmd.stamp = i_capture_stamp;
        cmd.mux   = i_mux_request;
        unique case (i_req_type)
            REQ_TICK:  cmd.kind = CMD_TICK;
            REQ_EDGE:  cmd.kind = CMD_EDGE;
            REQ_START: cmd.kind = CMD_START;
            REQ_NONE:  cmd.kind = CMD_NONE;
            default:   cmd.kind = CMD_NONE;
        endcase
    end

    assign o_in_stall = r_cnt == 2'(DEPTH);
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_pop && r_cnt != '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= cmd;
        end
    end

    assign o_q.valid = r_cnt != '0;
    assign o_q.cmd   = r_mem[r_rp];

endmodule

`default_nettype wire

/* design/ftc_back.sv */
// back end: measurement state, one-shot control, divider and result register
// depends on ftc_pkg and ftc_div
`default_nettype none

module ftc_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire ftc_pkg::t_q_if                  i_q,
    output logic                                 o_pop,
    input  wire logic                            i_cfg_we,
    input  wire logic [ftc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ftc_pkg::CLK_W-1:0]       i_cfg_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic                                 o_active,
    output logic                                 o_done_pulse,
    output logic [ftc_pkg::FREQ_W-1:0]           o_frequency_q8,
    output logic [ftc_pkg::RPM_W-1:0]            o_rpm_q8,
    output logic [ftc_pkg::COUNT_W-1:0]          o_edge_count,
    output logic [ftc_pkg::PERIOD_W-1:0]         o_period_ticks,
    output logic                                 o_timed_out,
    output logic [ftc_pkg::MUX_W-1:0]            o_mux_drive
);
    import ftc_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;

    logic [1:0]            r_state;
    logic [CFG_MS_W-1:0]   r_timeout;
    logic [CFG_MS_W-1:0]   r_settle;
    logic [CLK_W-1:0]      r_clk_hz;
    logic [MS_W-1:0]       r_now;
    logic [MS_W-1:0]       r_last_edge;
    logic [MS_W-1:0]       r_start;
    logic [STAMP_BITS-1:0] r_prev;
    logic [PERIOD_W-1:0]   r_period;
    logic [PERIOD_W-1:0]   r_period_new;
    logic [FREQ_W-1:0]     r_freq;
    logic [COUNT_W-1:0]    r_count;
    logic                  r_busy;
    logic [MUX_W-1:0]      r_mux;
    logic                  r_out_valid;

    logic [STAMP_BITS-1:0] diff;
    logic [PERIOD_W-1:0]   period;
    logic                  div_start;
    logic                  div_done;
    logic [DIVD_W-1:0]     quotient;
    logic [MS_W-1:0]       since_start;
    logic [MS_W-1:0]       since_edge;
    logic                  timed_out;
    logic                  finish;
    logic [FREQ_W-1:0]     freq_show;
    logic                  load;
    logic                  take;

    assign diff   = i_q.cmd.stamp - r_prev;
    assign period = {diff == '0, diff};

    assign take      = r_state == ST_IDLE && i_q.valid;
    assign o_pop     = take;
    assign div_start = take && i_q.cmd.kind == CMD_EDGE && r_count != '0;

    ftc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_clk_hz, FRAC_BITS'(0)}),
        .i_divisor  (period),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    assign since_start = r_now - r_start;
    assign since_edge  = r_now - r_last_edge;
    assign timed_out   = since_edge > MS_W'(r_timeout);
    assign finish      = r_busy && since_start >= MS_W'(r_settle)
                         && (r_count >= COUNT_W'(2) || timed_out
                             || since_start > MS_W'(r_timeout));
    assign freq_show   = (timed_out || r_count < COUNT_W'(2)) ? '0 : r_freq;
    assign load        = r_state == ST_CHECK && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
            r_settle  <= SETTLE_RESET;
            r_clk_hz  <= CLOCK_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TIMEOUT: r_timeout <= i_cfg_data[CFG_MS_W-1:0];
                CFG_SETTLE:  r_settle  <= i_cfg_data[CFG_MS_W-1:0];
                CFG_CLOCK:   r_clk_hz  <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_now       <= '0;
            r_last_edge <= '0;
            r_start     <= '0;
            r_prev      <= '0;
            r_period    <= '0;
            r_freq      <= '0;
            r_count     <= '0;
            r_busy      <= 1'b0;
            r_mux       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (take) begin
                        r_state <= ST_CHECK;
                        unique case (i_q.cmd.kind)
                            CMD_TICK: begin
                                r_now <= r_now + 1'b1;
                            end
                            CMD_EDGE: begin
                                r_prev      <= i_q.cmd.stamp;
                                r_last_edge <= r_now;
                                if (r_count == '0) begin
                                    r_count <= COUNT_W'(1);
                                end else begin
                                    r_period_new <= period;
                                    r_state      <= ST_DIV;
                                    if (r_count != COUNT_MAX) begin
                                        r_count <= r_count + 1'b1;
                                    end
                                end
                            end
                            CMD_START: begin
                                r_mux       <= i_q.cmd.mux;
                                r_count     <= '0;
                                r_freq      <= '0;
                                r_prev      <= '0;
                                r_period    <= '0;
                                r_last_edge <= r_now;
                                r_start     <= r_now;
                                r_busy      <= 1'b1;
                            end
                            CMD_NONE: ;
                            default: ;
                        endcase
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_freq   <= quotient;
                        r_period <= r_period_new;
                        r_state  <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (load) begin
                        if (finish) begin
                            r_busy <= 1'b0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_active       <= r_busy && !finish;
            o_done_pulse   <= finish;
            o_frequency_q8 <= freq_show;
            o_rpm_q8       <= {freq_show, 5'b0} - {4'b0, freq_show, 1'b0};
            o_edge_count   <= r_count;
            o_period_ticks <= r_period;
            o_timed_out    <= timed_out;
            o_mux_drive    <= r_mux;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* design/ftc_checker.sv */
// port-level checker for the fan tach one-shot capture block, with its bind
// depends on ftc_pkg and fan_tach_one_shot_capture
`default_nettype none

module ftc_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       o_out_valid,
    input  wire logic                       i_out_stall,
    input  wire logic                       o_active,
    input  wire logic                       o_done_pulse,
    input  wire logic [ftc_pkg::FREQ_W-1:0]  o_frequency_q8,
    input  wire logic [ftc_pkg::RPM_W-1:0]   o_rpm_q8,
    input  wire logic [ftc_pkg::COUNT_W-1:0] o_edge_count,
    input  wire logic                       o_timed_out
);
    import ftc_pkg::*;

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_frequency_q8))
        else $error("result dropped or changed while stalled");

    a_done_not_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_pulse |-> !o_active)
        else $error("one-shot reports done while still active");

    a_freq_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_timed_out || o_edge_count < COUNT_W'(2))
        |-> o_frequency_q8 == '0)
        else $error("frequency shown without a valid measurement");

    a_rpm_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_rpm_q8 == RPM_W'(o_frequency_q8) * RPM_W'(30))
        else $error("rpm is not thirty times the frequency");

endmodule

bind fan_tach_one_shot_capture ftc_checker u_ftc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_active       (o_active),
    .o_done_pulse   (o_done_pulse),
    .o_frequency_q8 (o_frequency_q8),
    .o_rpm_q8       (o_rpm_q8),
    .o_edge_count   (o_edge_count),
    .o_timed_out    (o_timed_out)
);

`default_nettype wire
